[design/ddrb_pkg.sv]
// Shared types and constants of the disk drive register block.
package ddrb_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_LOAD  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_DRIVE_POWER   = 2'd0,
    CFG_DISK_INSERTED = 2'd1,
    CFG_DISK_SIDE     = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] ADDR_LATCH_LO = 16'h4020;
  localparam logic [15:0] ADDR_LATCH_HI = 16'h4021;
  localparam logic [15:0] ADDR_TIMER_GO = 16'h4022;
  localparam logic [15:0] ADDR_WR_DATA  = 16'h4024;
  localparam logic [15:0] ADDR_CONTROL  = 16'h4025;
  localparam logic [15:0] ADDR_STATUS0  = 16'h4030;
  localparam logic [15:0] ADDR_RD_DATA  = 16'h4031;
  localparam logic [15:0] ADDR_STATUS1  = 16'h4032;
  localparam logic [15:0] ADDR_EXT_PORT = 16'h4033;

  localparam logic [15:0] TICK_STEP     = 16'd113;
  localparam logic [7:0]  EXT_POWER_BIT = 8'h80;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
    logic [17:0] image_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic       mirror_horizontal;
    logic       use_store;
  } result_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

[design/ddrb_in_if.sv]
// Request channel: valid/ready handshake with one request word.
interface ddrb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] bus_addr;
  logic [7:0]  bus_data;
  logic [17:0] image_index;

  modport source (output valid, req_type, bus_addr, bus_data, image_index, input ready);
  modport sink   (input valid, req_type, bus_addr, bus_data, image_index, output ready);
endinterface

[design/ddrb_out_if.sv]
// Result channel: valid/ready handshake with one result word.
interface ddrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_pulse;
  logic       mirror_horizontal;

  modport source (output valid, read_data, irq_pulse, mirror_horizontal, input ready);
  modport sink   (input valid, read_data, irq_pulse, mirror_horizontal, output ready);
endinterface

[design/ddrb_store.sv]
// Disk image byte store: one write or one registered read per cycle.
module ddrb_store #(
  parameter int DEPTH = 262000,
  parameter int AW    = 18
) (
  input  logic              clk_i,
  input  ddrb_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [7:0]        wdata_i,
  output logic [7:0]        rdata_o
);
  import ddrb_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ddrb_ctrl.sv]
// Controller registers, timer and head logic; one word handled per fire.
module ddrb_ctrl #(
  parameter int SIDE_BYTES = 65500,
  parameter int SIDES      = 4,
  parameter int AW         = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  ddrb_pkg::item_t     item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [1:0]          cfg_wdata_i,
  output ddrb_pkg::result_t   res_o,
  output ddrb_pkg::mem_ctl_t  mem_ctl_o,
  output logic [AW-1:0]       mem_addr_o,
  output logic [7:0]          mem_wdata_o
);
  import ddrb_pkg::*;

  localparam logic [16:0] SideLimit  = 17'(SIDE_BYTES);
  localparam logic [31:0] StoreBytes = 32'(SIDES * SIDE_BYTES);
  localparam logic [3:0]  SidesW     = 4'(SIDES);

  logic [15:0] head_q, head_d;
  logic [15:0] latch_q, latch_d;
  logic [15:0] count_q, count_d;
  logic        armed_q, armed_d;
  logic        xfer_irq_q, xfer_irq_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic        stat0_q, stat0_d;
  logic [1:0]  skip_q, skip_d;
  logic        mirror_q, mirror_d;
  logic        power_q, inserted_q;
  logic [1:0]  side_q;

  logic [3:0]    side_sel;
  logic [AW-1:0] side_base;
  logic [15:0]   head_m2;
  logic [15:0]   seek_pos;
  logic          re_c, we_c;
  logic [AW-1:0] addr_c;
  result_t       res_c;

  // side mod SIDES: side <= 3 < 2*SIDES once SIDES >= 2
  always_comb begin
    if (SIDES == 1) begin
      side_sel = '0;
    end else if ({2'b00, side_q} >= SidesW) begin
      side_sel = {2'b00, side_q} - SidesW;
    end else begin
      side_sel = {2'b00, side_q};
    end
  end

  assign side_base = AW'(32'(side_sel) * 32'(SIDE_BYTES));
  assign head_m2   = head_q - 16'd2;

  always_comb begin
    head_d     = head_q;
    latch_d    = latch_q;
    count_d    = count_q;
    armed_d    = armed_q;
    xfer_irq_d = xfer_irq_q;
    ctrl_d     = ctrl_q;
    stat0_d    = stat0_q;
    skip_d     = skip_q;
    mirror_d   = mirror_q;
    re_c       = 1'b0;
    we_c       = 1'b0;
    addr_c     = '0;
    seek_pos   = head_q;
    res_c      = '0;

    case (req_type_e'(item_i.req_type))
      REQ_READ: begin
        case (item_i.bus_addr)
          ADDR_STATUS0: begin
            res_c.read_data = {7'd0, stat0_q};
            stat0_d         = 1'b0;
          end
          ADDR_RD_DATA: begin
            if ({1'b0, head_q} < SideLimit) begin
              re_c            = 1'b1;
              res_c.use_store = 1'b1;
              addr_c          = side_base + AW'(head_q);
            end
            head_d = head_q + 16'd1;
          end
          ADDR_STATUS1: res_c.read_data = {7'd0, ~inserted_q};
          ADDR_EXT_PORT: res_c.read_data = power_q ? EXT_POWER_BIT : 8'd0;
          default: ;
        endcase
      end
      REQ_WRITE: begin
        case (item_i.bus_addr)
          ADDR_LATCH_LO: latch_d = {latch_q[15:8], item_i.bus_data};
          ADDR_LATCH_HI: latch_d = {item_i.bus_data, latch_q[7:0]};
          ADDR_TIMER_GO: begin
            count_d = latch_q;
            armed_d = (item_i.bus_data != 8'd0);
          end
          ADDR_WR_DATA: begin
            if (!ctrl_q[2]) begin
              if (skip_q != 2'd0) begin
                skip_d = skip_q - 2'd1;
              end else if ({1'b0, head_m2} < SideLimit) begin
                we_c   = 1'b1;
                addr_c = side_base + AW'(head_m2);
              end
            end
          end
          ADDR_CONTROL: begin
            xfer_irq_d = item_i.bus_data[7];
            if (item_i.bus_data[1]) begin
              seek_pos = 16'd0;
            end
            if (!item_i.bus_data[2]) begin
              skip_d = 2'd2;
            end
            // falling bit 6 backs the head up after any seek
            if (!item_i.bus_data[6] && ctrl_q[6]) begin
              head_d = seek_pos - 16'd2;
            end else begin
              head_d = seek_pos;
            end
            mirror_d = item_i.bus_data[3];
            ctrl_d   = item_i.bus_data;
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        res_c.irq_pulse = xfer_irq_q;
        if (armed_q) begin
          if (count_q < TICK_STEP) begin
            armed_d         = 1'b0;
            stat0_d         = 1'b1;
            res_c.irq_pulse = 1'b1;
          end else begin
            count_d = count_q - TICK_STEP;
          end
        end
      end
      REQ_LOAD: begin
        if (32'(item_i.image_index) < StoreBytes) begin
          we_c   = 1'b1;
          addr_c = AW'(item_i.image_index);
        end
      end
      default: ;
    endcase

    res_c.mirror_horizontal = mirror_d;
  end

  assign res_o       = res_c;
  assign mem_ctl_o   = '{re: fire_i && re_c, we: fire_i && we_c};
  assign mem_addr_o  = addr_c;
  assign mem_wdata_o = item_i.bus_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      latch_q    <= '0;
      count_q    <= '0;
      armed_q    <= 1'b0;
      xfer_irq_q <= 1'b0;
      ctrl_q     <= '0;
      stat0_q    <= 1'b0;
      skip_q     <= '0;
      mirror_q   <= 1'b0;
    end else if (fire_i) begin
      head_q     <= head_d;
      latch_q    <= latch_d;
      count_q    <= count_d;
      armed_q    <= armed_d;
      xfer_irq_q <= xfer_irq_d;
      ctrl_q     <= ctrl_d;
      stat0_q    <= stat0_d;
      skip_q     <= skip_d;
      mirror_q   <= mirror_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q    <= 1'b1;
      inserted_q <= 1'b0;
      side_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DRIVE_POWER:   power_q    <= cfg_wdata_i[0];
        CFG_DISK_INSERTED: inserted_q <= cfg_wdata_i[0];
        CFG_DISK_SIDE:     side_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule

[design/disk_drive_register_block.sv]
// Disk drive register block: input register, controller, store and result register.
// Takes one request word per cycle unless the result channel stalls, and returns one
// result word for each: the accepted word sits in the input register while the
// controller registers update and the store is accessed, then the result register
// (with the store's registered read data) presents it. Back-pressure on the result
// channel stalls the input register; the store has one port, read or write per cycle.
// The store holds SIDES * SIDE_BYTES bytes and is not cleared after reset.
module disk_drive_register_block #(
  parameter int SIDE_BYTES = 65500,
  parameter int SIDES      = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddrb_in_if.sink    in_i,
  ddrb_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [1:0] cfg_wdata_i
);
  import ddrb_pkg::*;

  localparam int Depth = SIDES * SIDE_BYTES;
  localparam int AW    = $clog2(Depth);

  logic     s1_valid_q;
  item_t    s1_item_q;
  logic     s1_fire;
  logic     s2_free;
  logic     out_valid_q;
  result_t  out_res_q;
  result_t  res;
  mem_ctl_t mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  assign s2_free  = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && s2_free;
  assign in_i.ready = !s1_valid_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q <= '{req_type:    in_i.req_type,
                     bus_addr:    in_i.bus_addr,
                     bus_data:    in_i.bus_data,
                     image_index: in_i.image_index};
    end
  end

  ddrb_ctrl #(
    .SIDE_BYTES(SIDE_BYTES),
    .SIDES     (SIDES),
    .AW        (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .item_i     (s1_item_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res),
    .mem_ctl_o  (mem_ctl),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata)
  );

  ddrb_store #(
    .DEPTH(Depth),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_res_q <= res;
    end
  end

  // store read data is held in the store's read register until the next read
  assign out_o.valid             = out_valid_q;
  assign out_o.read_data         = out_res_q.use_store ? mem_rdata : out_res_q.read_data;
  assign out_o.irq_pulse         = out_res_q.irq_pulse;
  assign out_o.mirror_horizontal = out_res_q.mirror_horizontal;

  a_one_store_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.re && mem_ctl.we))
    else $error("store read and write in the same cycle");

  a_store_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.re || mem_ctl.we) |-> s1_fire)
    else $error("store accessed without a word advancing");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("advanced word produced no result");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input register lost a word under stall");

endmodule

[tb/disk_drive_register_block_tb.sv]
// Self-checking testbench of the disk drive register block with its own model.
`timescale 1ns / 100ps

module disk_drive_register_block_tb;
  import ddrb_pkg::*;

  localparam int SIDE_BYTES  = 65500;
  localparam int SIDES       = 4;
  localparam int STORE_BYTES = SIDE_BYTES * SIDES;

  localparam logic [15:0] ADDR_WR_LIMIT = 16'h4040;

  // control register bits
  localparam int CTL_SEEK     = 1;
  localparam int CTL_WR_HOLD  = 2;
  localparam int CTL_MIRROR   = 3;
  localparam int CTL_REWIND   = 6;
  localparam int CTL_XFER_IRQ = 7;

  localparam int IDLE_PCT     = 24;
  localparam int STEADY_LO    = 500;
  localparam int STEADY_HI    = 800;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic       mirror_horizontal;
  } reply_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [1:0] cfg_wdata_i;

  ddrb_in_if  req_ch ();
  ddrb_out_if res_ch ();

  disk_drive_register_block #(
    .SIDE_BYTES(SIDE_BYTES),
    .SIDES     (SIDES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  item_t  request_q[$];
  reply_t reply_q[$];

  int errors, n_items, n_reads, n_store_reads, n_writes, n_ticks, n_loads, n_irqs, n_cfg;
  int words_in, words_out, hold_left;
  bit hold_done;

  // drive state as the block should hold it
  logic [7:0]  disk_image [STORE_BYTES];
  bit          image_set  [STORE_BYTES];
  logic [15:0] head, latch, count;
  logic        armed, xfer_irq, mirror;
  logic [7:0]  ctrl, status0;
  logic [1:0]  skip;
  logic        power, inserted;
  logic [1:0]  side;

  function automatic int side_base();
    return (int'(side) % SIDES) * SIDE_BYTES;
  endfunction

  function automatic item_t make_req(req_type_e t, logic [15:0] a, logic [7:0] d,
                                     logic [17:0] i);
    item_t it;
    it.req_type    = t;
    it.bus_addr    = a;
    it.bus_data    = d;
    it.image_index = i;
    return it;
  endfunction

  task automatic drive_request(input item_t it, output reply_t r);
    int          base;
    logic [15:0] p;
    logic [7:0]  d;
    base = side_base();
    d    = it.bus_data;
    r    = '0;
    case (req_type_e'(it.req_type))
      REQ_READ: begin
        n_reads++;
        case (it.bus_addr)
          ADDR_STATUS0: begin
            r.read_data = status0;
            status0[0]  = 1'b0;
          end
          ADDR_RD_DATA: begin
            if (head < SIDE_BYTES) begin
              r.read_data = disk_image[base + int'(head)];
              n_store_reads++;
            end
            head = head + 16'd1;
          end
          ADDR_STATUS1:  r.read_data = inserted ? 8'h00 : 8'h01;
          ADDR_EXT_PORT: r.read_data = power ? EXT_POWER_BIT : 8'h00;
          default: ;
        endcase
      end
      REQ_WRITE: begin
        n_writes++;
        if (it.bus_addr < ADDR_WR_LIMIT) begin
          case (it.bus_addr)
            ADDR_LATCH_LO: latch[7:0]  = d;
            ADDR_LATCH_HI: latch[15:8] = d;
            ADDR_TIMER_GO: begin
              count = latch;
              armed = (d != 8'h00);
            end
            ADDR_WR_DATA: begin
              if (!ctrl[CTL_WR_HOLD]) begin
                if (skip != 2'd0) begin
                  skip = skip - 2'd1;
                end else begin
                  p = head - 16'd2;
                  if (p < SIDE_BYTES) begin
                    disk_image[base + int'(p)] = d;
                    image_set[base + int'(p)]  = 1'b1;
                  end
                end
              end
            end
            ADDR_CONTROL: begin
              xfer_irq = d[CTL_XFER_IRQ];
              if (d[CTL_SEEK]) head = 16'd0;
              if (!d[CTL_WR_HOLD]) skip = 2'd2;
              if (!d[CTL_REWIND] && ctrl[CTL_REWIND]) head = head - 16'd2;
              mirror = d[CTL_MIRROR];
              ctrl   = d;
            end
            default: ;
          endcase
        end
      end
      REQ_TICK: begin
        n_ticks++;
        r.irq_pulse = xfer_irq;
        if (armed) begin
          if (count < TICK_STEP) begin
            armed       = 1'b0;
            status0[0]  = 1'b1;
            r.irq_pulse = 1'b1;
          end else begin
            count = count - TICK_STEP;
          end
        end
      end
      default: begin
        n_loads++;
        if (it.image_index < STORE_BYTES) begin
          disk_image[it.image_index] = d;
          image_set[it.image_index]  = 1'b1;
        end
      end
    endcase
    r.mirror_horizontal = mirror;
    if (r.irq_pulse) n_irqs++;
  endtask

  task automatic post(input item_t it);
    reply_t r;
    drive_request(it, r);
    request_q.push_back(it);
    reply_q.push_back(r);
    n_items++;
  endtask

  // a data port read of a never written byte gets that byte loaded first
  task automatic issue(input item_t it);
    int at;
    at = side_base() + int'(head);
    if (req_type_e'(it.req_type) == REQ_READ && it.bus_addr == ADDR_RD_DATA &&
        head < SIDE_BYTES && !image_set[at])
      post(make_req(REQ_LOAD, 16'($urandom), 8'($urandom), 18'(at)));
    post(it);
  endtask

  task automatic bus_read(input logic [15:0] a);
    issue(make_req(REQ_READ, a, 8'($urandom), 18'($urandom)));
  endtask

  task automatic bus_write(input logic [15:0] a, input logic [7:0] d);
    issue(make_req(REQ_WRITE, a, d, 18'($urandom)));
  endtask

  task automatic scan_tick();
    issue(make_req(REQ_TICK, 16'($urandom), 8'($urandom), 18'($urandom)));
  endtask

  task automatic image_load(input logic [17:0] i, input logic [7:0] d);
    issue(make_req(REQ_LOAD, 16'($urandom), d, i));
  endtask

  task automatic drain();
    while (reply_q.size() != 0 || request_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_DRIVE_POWER:   power    = v[0];
      CFG_DISK_INSERTED: inserted = v[0];
      default:           side     = v;
    endcase
    n_cfg++;
  endtask

  task automatic set_drive(input logic p, input logic ins, input logic [1:0] s);
    set_reg(CFG_DRIVE_POWER, {1'b0, p});
    set_reg(CFG_DISK_INSERTED, {1'b0, ins});
    set_reg(CFG_DISK_SIDE, s);
  endtask

  task automatic random_traffic(input int n);
    int         stop, pick, k;
    logic [7:0] c;
    stop = n_items + n;
    while (n_items < stop) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // enable writes, then a run of data words
        c = 8'($urandom);
        c[CTL_WR_HOLD] = 1'b0;
        bus_write(ADDR_CONTROL, c);
        k = $urandom_range(6, 1);
        repeat (k) bus_write(ADDR_WR_DATA, 8'($urandom));
        if ($urandom_range(1)) repeat ($urandom_range(3, 1)) bus_read(ADDR_RD_DATA);
      end else if (pick < 38) begin
        if ($urandom_range(1)) begin
          c = 8'($urandom);
          c[CTL_SEEK] = 1'b1;
          bus_write(ADDR_CONTROL, c);
        end
        repeat ($urandom_range(5, 1)) bus_read(ADDR_RD_DATA);
      end else if (pick < 56) begin
        bus_write(ADDR_LATCH_LO, 8'($urandom));
        bus_write(ADDR_LATCH_HI,
                  ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2)));
        bus_write(ADDR_TIMER_GO,
                  ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
        repeat ($urandom_range(8, 1)) begin
          scan_tick();
          if ($urandom_range(3) == 0) bus_read(ADDR_STATUS0);
        end
      end else if (pick < 66) begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(4) == 0)
            image_load(18'($urandom), 8'($urandom));
          else
            image_load(18'((side_base() + int'(head) + $urandom_range(4)) % STORE_BYTES),
                       8'($urandom));
        end
      end else if (pick < 76) begin
        // raise then drop the rewind bit, then work around the head
        c = 8'($urandom);
        c[CTL_REWIND] = 1'b1;
        bus_write(ADDR_CONTROL, c);
        c = 8'($urandom);
        c[CTL_REWIND] = 1'b0;
        bus_write(ADDR_CONTROL, c);
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(1)) bus_read(ADDR_RD_DATA);
          else bus_write(ADDR_WR_DATA, 8'($urandom));
        end
      end else if (pick < 86) begin
        case ($urandom_range(3))
          0:       bus_read(ADDR_STATUS0);
          1:       bus_read(ADDR_STATUS1);
          2:       bus_read(ADDR_EXT_PORT);
          default: bus_read(16'($urandom));
        endcase
      end else begin
        issue(make_req(req_type_e'($urandom_range(3)),
                       $urandom_range(1) ? 16'(16'h4020 + $urandom_range(32)) : 16'($urandom),
                       8'($urandom), 18'($urandom)));
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    item_t nxt;
    bit    steady;
    if (!rst_ni) begin
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= '0;
      req_ch.bus_addr    <= '0;
      req_ch.bus_data    <= '0;
      req_ch.image_index <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) words_in++;
      steady = (words_in >= STEADY_LO && words_in < STEADY_HI);
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = request_q.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.req_type    <= nxt.req_type;
          req_ch.bus_addr    <= nxt.bus_addr;
          req_ch.bus_data    <= nxt.bus_data;
          req_ch.image_index <= nxt.image_index;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready control
  always @(posedge clk_i or negedge rst_ni) begin : mon
    reply_t want, got;
    bit     steady;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.read_data, res_ch.irq_pulse, res_ch.mirror_horizontal};
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word read_data=%02h irq=%0b mirror=%0b", $time,
                   got.read_data, got.irq_pulse, got.mirror_horizontal);
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: word %0d expected read_data=%02h irq=%0b mirror=%0b, got %02h %0b %0b",
                     $time, words_out, want.read_data, want.irq_pulse,
                     want.mirror_horizontal, got.read_data, got.irq_pulse,
                     got.mirror_horizontal);
          end
        end
        words_out++;
      end
      steady = (words_out >= STEADY_LO && words_out < STEADY_HI);
      if (!hold_done && words_out >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.req_type    = '0;
    req_ch.bus_addr    = '0;
    req_ch.bus_data    = '0;
    req_ch.image_index = '0;
    res_ch.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;

    foreach (image_set[i]) image_set[i] = 1'b0;
    head = '0; latch = '0; count = '0; armed = 1'b0; xfer_irq = 1'b0; mirror = 1'b0;
    ctrl = '0; status0 = '0; skip = '0;
    power = 1'b1; inserted = 1'b0; side = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: status ports, store edges, rewind past zero, timer fire
    bus_read(ADDR_STATUS0);
    bus_read(ADDR_STATUS1);
    bus_read(ADDR_EXT_PORT);
    bus_read(16'hFFFF);
    image_load(18'd0, 8'hA5);
    image_load(18'(STORE_BYTES - 1), 8'hFF);
    image_load(18'h3FFFF, 8'h00);                // beyond the store, dropped
    bus_read(ADDR_RD_DATA);
    bus_write(ADDR_CONTROL, 8'h48);
    bus_write(ADDR_CONTROL, 8'h82);              // seek, then rewind wraps to 65534
    bus_read(ADDR_RD_DATA);                      // out of side
    bus_write(ADDR_WR_DATA, 8'h11);
    bus_write(ADDR_WR_DATA, 8'h22);
    bus_write(ADDR_WR_DATA, 8'h33);              // lands out of side, dropped
    scan_tick();
    bus_write(ADDR_CONTROL, 8'h04);
    bus_write(ADDR_LATCH_LO, 8'hC8);
    bus_write(ADDR_LATCH_HI, 8'h00);
    bus_write(ADDR_TIMER_GO, 8'h01);
    scan_tick();
    scan_tick();
    bus_read(ADDR_STATUS0);
    bus_read(ADDR_STATUS0);
    bus_write(ADDR_WR_LIMIT, 8'hFF);
    bus_write(16'hFFFF, 8'hFF);
    bus_write(ADDR_TIMER_GO, 8'h00);
    scan_tick();

    random_traffic(200);
    set_drive(1'b0, 1'b1, 2'd3);
    random_traffic(200);
    set_drive(1'b1, 1'b1, 2'd1);
    random_traffic(200);
    set_drive(1'b0, 1'b0, 2'd2);
    random_traffic(200);
    set_drive(1'b1, 1'b1, 2'd3);
    random_traffic(200);
    set_drive(1'b1, 1'b0, 2'd0);
    random_traffic(225);

    drain();
    repeat (10) @(posedge clk_i);
    if (reply_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, reply_q.size());
    end

    $display("Run: %0d requests, %0d reads (%0d from the disk store), %0d writes,",
             n_items, n_reads, n_store_reads, n_writes);
    $display("     %0d ticks (%0d interrupts), %0d image loads, %0d register writes",
             n_ticks, n_irqs, n_loads, n_cfg);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/ddrb_pkg.sv
design/ddrb_in_if.sv
design/ddrb_out_if.sv
design/ddrb_store.sv
design/ddrb_ctrl.sv
design/disk_drive_register_block.sv
tb/disk_drive_register_block_tb.sv
